>>> sv/fts_pkg.sv
// Shared types and codes for the file transfer sender controller.
// Used by fts_decode, fts_emit and file_transfer_sender_fsm; depends on nothing.
package fts_pkg;

  localparam int MaxActions = 5;
  localparam int CountW     = 3;

  typedef logic [3:0] event_t;
  typedef logic [3:0] act_t;

  // Event codes.
  localparam event_t EV_ENTERED    = 4'd0;
  localparam event_t EV_SEND_DATA  = 4'd1;
  localparam event_t EV_ABANDON    = 4'd2;
  localparam event_t EV_CANCEL_NTC = 4'd3;
  localparam event_t EV_SUSP_NTC   = 4'd4;
  localparam event_t EV_PUT        = 4'd5;
  localparam event_t EV_SUSPEND    = 4'd6;
  localparam event_t EV_RESUME     = 4'd7;
  localparam event_t EV_CANCEL     = 4'd8;
  localparam event_t EV_REPORT     = 4'd9;
  localparam event_t EV_FREEZE     = 4'd10;
  localparam event_t EV_THAW       = 4'd11;

  // Action codes.
  localparam act_t A_TRANS_IND = 4'd0;
  localparam act_t A_SEND_META = 4'd1;
  localparam act_t A_SEND_EOF  = 4'd2;
  localparam act_t A_EOF_SENT  = 4'd3;
  localparam act_t A_FINISHED  = 4'd4;
  localparam act_t A_ISSUE     = 4'd5;
  localparam act_t A_ABANDONED = 4'd6;
  localparam act_t A_SUSPENDED = 4'd7;
  localparam act_t A_RESUMED   = 4'd8;
  localparam act_t A_REPORT    = 4'd9;
  localparam act_t A_OPEN      = 4'd10;
  localparam act_t A_DATA      = 4'd11;
  localparam act_t A_CLOSE     = 4'd12;
  localparam act_t A_REJECT    = 4'd13;

  typedef enum logic [1:0] {
    PH_META = 2'd0,
    PH_SEND = 2'd1,
    PH_DONE = 2'd2
  } phase_t;

  typedef struct packed {
    phase_t phase;
    logic   suspended;
    logic   frozen;
    logic   cancel;
  } ctl_state_t;

  typedef struct packed {
    act_t   action;
    event_t req;
    logic   cond;
  } entry_t;

  typedef struct packed {
    logic [CountW-1:0]             count;
    entry_t [MaxActions-1:0]       entries;
  } action_list_t;

  typedef struct packed {
    event_t ev;
    logic   in_prog;
    logic   ready;
    logic   done;
  } event_item_t;

  function automatic entry_t mk(input act_t a, input event_t r, input logic c);
    entry_t e;
    e.action = a;
    e.req    = r;
    e.cond   = c;
    return e;
  endfunction

endpackage

>>> sv/fts_decode.sv
// Combinational event decoder: turns one event and the controller state
// into an ordered action list and the next state. Depends on fts_pkg.
module fts_decode (
  input  fts_pkg::event_item_t  item,
  input  fts_pkg::ctl_state_t   st,
  output fts_pkg::action_list_t list,
  output fts_pkg::ctl_state_t   st_next
);
  import fts_pkg::*;

  entry_t eof_e;
  assign eof_e = mk(A_SEND_EOF, EV_ENTERED, st.cancel);

  always_comb begin
    list    = '0;
    st_next = st;
    case (st.phase)
      PH_META: begin
        if (item.ev == EV_ENTERED) begin
          st_next.suspended = 1'b0;
          st_next.frozen    = 1'b0;
          st_next.cancel    = 1'b0;
        end else if (item.ev == EV_PUT) begin
          list.entries[0] = mk(A_TRANS_IND, EV_ENTERED, 1'b0);
          list.entries[1] = mk(A_SEND_META, EV_ENTERED, 1'b0);
          if (item.in_prog) begin
            st_next.phase   = PH_SEND;
            list.entries[2] = mk(A_ISSUE, EV_ENTERED, 1'b0);
            list.count      = 3'd3;
          end else begin
            list.entries[2] = eof_e;
            list.entries[3] = mk(A_EOF_SENT, EV_ENTERED, 1'b0);
            list.entries[4] = mk(A_FINISHED, EV_ENTERED, 1'b0);
            list.count      = 3'd5;
          end
        end else begin
          list.entries[0] = mk(A_REJECT, EV_ENTERED, 1'b0);
          list.count      = 3'd1;
        end
      end
      PH_SEND: begin
        case (item.ev)
          EV_ENTERED: begin
            list.entries[0] = mk(A_OPEN, EV_ENTERED, 1'b0);
            list.entries[1] = mk(A_ISSUE, EV_SEND_DATA, 1'b0);
            list.count      = 3'd2;
          end
          EV_SEND_DATA: begin
            if (!st.suspended && !st.frozen) begin
              if (item.ready && item.done) begin
                list.entries[0] = mk(A_DATA, EV_ENTERED, 1'b0);
                list.entries[1] = eof_e;
                list.entries[2] = mk(A_EOF_SENT, EV_ENTERED, 1'b0);
                list.entries[3] = mk(A_FINISHED, EV_ENTERED, 1'b0);
                list.entries[4] = mk(A_CLOSE, EV_ENTERED, 1'b0);
                list.count      = 3'd5;
                st_next.phase   = PH_DONE;
              end else if (item.ready) begin
                list.entries[0] = mk(A_DATA, EV_ENTERED, 1'b0);
                list.entries[1] = mk(A_ISSUE, EV_SEND_DATA, 1'b0);
                list.count      = 3'd2;
              end else begin
                list.entries[0] = mk(A_ISSUE, EV_SEND_DATA, 1'b0);
                list.count      = 3'd1;
              end
            end
          end
          EV_ABANDON: begin
            list.entries[0] = mk(A_ABANDONED, EV_ENTERED, 1'b0);
            list.entries[1] = mk(A_CLOSE, EV_ENTERED, 1'b0);
            list.count      = 3'd2;
            st_next.phase   = PH_DONE;
          end
          EV_CANCEL_NTC: begin
            list.entries[0] = eof_e;
            list.entries[1] = mk(A_FINISHED, EV_ENTERED, 1'b0);
            list.entries[2] = mk(A_CLOSE, EV_ENTERED, 1'b0);
            list.count      = 3'd3;
            st_next.phase   = PH_DONE;
          end
          EV_SUSP_NTC: begin
            if (!st.suspended) begin
              list.entries[0]   = mk(A_SUSPENDED, EV_ENTERED, 1'b0);
              list.count        = 3'd1;
              st_next.suspended = 1'b1;
            end
          end
          EV_SUSPEND: begin
            list.entries[0] = mk(A_ISSUE, EV_SUSP_NTC, 1'b0);
            list.count      = 3'd1;
          end
          EV_RESUME: begin
            if (st.suspended) begin
              list.entries[0]   = mk(A_RESUMED, EV_ENTERED, 1'b0);
              list.entries[1]   = mk(A_ISSUE, EV_SEND_DATA, 1'b0);
              list.count        = 3'd2;
              st_next.suspended = 1'b0;
            end else begin
              list.entries[0] = mk(A_ISSUE, EV_SEND_DATA, 1'b0);
              list.count      = 3'd1;
            end
          end
          EV_CANCEL: begin
            st_next.cancel  = 1'b1;
            list.entries[0] = mk(A_ISSUE, EV_CANCEL_NTC, 1'b0);
            list.count      = 3'd1;
          end
          EV_REPORT: begin
            list.entries[0] = mk(A_REPORT, EV_ENTERED, 1'b0);
            list.count      = 3'd1;
          end
          EV_FREEZE: begin
            st_next.frozen = 1'b1;
          end
          EV_THAW: begin
            if (st.frozen) begin
              st_next.frozen  = 1'b0;
              list.entries[0] = mk(A_ISSUE, EV_SEND_DATA, 1'b0);
              list.count      = 3'd1;
            end
          end
          default: begin
            list.entries[0] = mk(A_REJECT, EV_ENTERED, 1'b0);
            list.count      = 3'd1;
          end
        endcase
      end
      default: begin
        // Completed: every event is dropped without actions.
      end
    endcase
  end

endmodule

>>> sv/fts_emit.sv
// Result serializer: holds one decoded action list and hands its items out
// one per cycle while out_ready is high, marking the final one. Depends on fts_pkg.
module fts_emit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  fts_pkg::action_list_t list_in,
  input  logic                  out_ready,
  output logic                  busy,
  output logic                  out_last,
  output fts_pkg::entry_t       out_entry
);
  import fts_pkg::*;

  action_list_t      list;
  logic [CountW-1:0] idx;
  logic              adv;

  assign out_last  = (idx == list.count - 3'd1);
  assign out_entry = list.entries[idx];
  assign adv       = busy && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= (list_in.count != '0);
      idx  <= '0;
    end else if (adv) begin
      if (out_last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      list <= list_in;
    end
  end

endmodule

>>> sv/file_transfer_sender_fsm.sv
// Top level of the unacknowledged file transfer sender controller.
// Instantiates fts_decode and fts_emit; depends on fts_pkg.

// Each accepted event item is held in an input register, decoded
// combinationally into zero to five action items, and the controller state
// (phase, suspended, frozen, cancel condition) is updated when the decoded
// list moves into the output serializer. Actions then leave on the master
// side one per cycle while m_tready is high, the final one of each event
// flagged with m_tlast. The next event is taken while the previous event's
// actions are still draining, and its list is loaded in the same cycle the
// last action is taken. The transaction number register is written through
// the cfg channel and is copied into every action item. The user must write
// it only while no event is in flight; the block itself does not enforce
// this.
module file_transfer_sender_fsm (
  input  logic        clk,
  input  logic        rst,
  // Configuration write: transaction number.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  // Event input.
  input  logic        s_tvalid,
  output logic        s_tready,
  // [3:0] event_code, [4] transfer_in_progress, [5] transport_ready,
  // [6] send_complete, [7] zero.
  input  logic [7:0]  s_tdata,
  // Action output.
  output logic        m_tvalid,
  input  logic        m_tready,
  // [3:0] action, [7:4] requested_event, [8] eof_condition,
  // [16:9] transaction_tag, [23:17] zero.
  output logic [23:0] m_tdata,
  output logic        m_tlast    // last_action
);
  import fts_pkg::*;

  logic         [7:0] trans_num;
  event_item_t        item;
  logic               item_valid;
  ctl_state_t         st;
  ctl_state_t         st_next;
  action_list_t       list;
  logic               xfer;
  logic               em_busy;
  logic               em_last;
  entry_t             em_entry;

  // Configuration register; always ready.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      trans_num <= '0;
    end else if (cfg_valid) begin
      trans_num <= cfg_data;
    end
  end

  // The held event moves on once the serializer is empty or is handing
  // over its final item in this cycle.
  assign xfer     = item_valid && (!em_busy || (m_tready && em_last));
  assign s_tready = !item_valid || xfer;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.ev      <= s_tdata[3:0];
      item.in_prog <= s_tdata[4];
      item.ready   <= s_tdata[5];
      item.done    <= s_tdata[6];
    end
  end

  // Controller state commits when the decoded list is handed on.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase     <= PH_META;
      st.suspended <= 1'b0;
      st.frozen    <= 1'b0;
      st.cancel    <= 1'b0;
    end else if (xfer) begin
      st <= st_next;
    end
  end

  fts_decode u_decode (
    .item    (item),
    .st      (st),
    .list    (list),
    .st_next (st_next)
  );

  fts_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .load      (xfer),
    .list_in   (list),
    .out_ready (m_tready),
    .busy      (em_busy),
    .out_last  (em_last),
    .out_entry (em_entry)
  );

  assign m_tvalid = em_busy;
  assign m_tlast  = em_last;
  assign m_tdata  = {7'd0, trans_num, em_entry.cond, em_entry.req, em_entry.action};

  // A new list may only replace one whose final item leaves in this cycle.
  a_load_only_at_end: assert property (@(posedge clk) disable iff (rst)
    xfer && em_busy |-> m_tready && em_last)
    else $error("action list overwritten before it drained");

  // The completed phase never produces actions.
  a_done_silent: assert property (@(posedge clk) disable iff (rst)
    item_valid && (st.phase == PH_DONE) |-> list.count == '0)
    else $error("actions decoded in completed phase");

  // The decoder never produces more actions than the serializer holds.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    item_valid |-> list.count <= 3'd5)
    else $error("action count out of range");

endmodule
